### sv/hrhs_pkg.sv
// shared constants, codes and helpers of the http response header scanner
`default_nettype none
package hrhs_pkg;

  // counter and field widths
  localparam int COUNT_BITS   = 20;
  localparam int CFG_BITS     = 21;
  localparam int STATUS_BITS  = 16;
  localparam int LENGTH_BITS  = 32;
  localparam int KEY_LENGTH   = 15;
  localparam int KEY_POS_BITS = 5;

  // item kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // stop reasons
  localparam logic [1:0] STOP_RUNNING = 2'd0;
  localparam logic [1:0] STOP_BODY    = 2'd1;
  localparam logic [1:0] STOP_FULL    = 2'd2;
  localparam logic [1:0] STOP_CLOSED  = 2'd3;

  // ascii bytes of interest
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // buffer size after reset
  localparam logic [CFG_BITS-1:0] BUFFER_SIZE_RESET = CFG_BITS'(4096);

  // lower-case header key, one character per match position
  function automatic logic [7:0] key_char(input logic [KEY_POS_BITS-1:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = "c";
      5'd1:    c = "o";
      5'd2:    c = "n";
      5'd3:    c = "t";
      5'd4:    c = "e";
      5'd5:    c = "n";
      5'd6:    c = "t";
      5'd7:    c = "-";
      5'd8:    c = "l";
      5'd9:    c = "e";
      5'd10:   c = "n";
      5'd11:   c = "g";
      5'd12:   c = "t";
      5'd13:   c = "h";
      5'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

endpackage
`default_nettype wire

### sv/hrhs_ifs.sv
// valid/ready channel interfaces of the http response header scanner
`default_nettype none

// input items: one response byte or an event
interface hrhs_in_if import hrhs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  modport source(output valid, kind, data_byte, input ready);
  modport sink(input valid, kind, data_byte, output ready);
endinterface

// result items: scanner state after each input item
interface hrhs_out_if import hrhs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   header_done;
  logic [COUNT_BITS-1:0]  header_length;
  logic [STATUS_BITS-1:0] status_code;
  logic [LENGTH_BITS-1:0] content_length;
  logic [COUNT_BITS-1:0]  total_bytes;
  logic                   done_res;
  logic [1:0]             stop_reason;
  modport source(output valid, header_done, header_length, status_code, content_length,
                 total_bytes, done_res, stop_reason, input ready);
  modport sink(input valid, header_done, header_length, status_code, content_length,
               total_bytes, done_res, stop_reason, output ready);
endinterface

// configuration writes of the buffer size register
interface hrhs_cfg_if import hrhs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] buffer_size;
  modport source(output valid, buffer_size, input ready);
  modport sink(input valid, buffer_size, output ready);
endinterface
`default_nettype wire

### sv/http_response_header_scanner.sv
// HTTP response header scanner, a byte-at-a-time response tracker
// Each accepted item is one response byte, a connection-closed event or a
// start-of-response event that clears all state. The block takes one item per
// clock cycle while no unread result holds it back: the whole update (byte
// counting, CR LF CR LF detection, status and content-length parsing,
// completion check) is done in the cycle of acceptance, and one result item
// showing the state after that item is held in an output register that the
// next item may replace in the same cycle it is taken. Completion is flagged
// when the body reaches a nonzero content length (highest priority), when
// buffer_size minus one bytes have been counted, or on a close event; after
// that further bytes are ignored. The buffer_size register may be written at
// any time the block is idle; the port is always ready.
`default_nettype none
module http_response_header_scanner import hrhs_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  hrhs_in_if.sink   rx,
  hrhs_out_if.source result,
  hrhs_cfg_if.sink  cfg
);

  localparam logic [31:0] HEADER_END = {CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};

  logic [COUNT_BITS-1:0] limit, limit_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [23:0]           recent_bytes, recent_bytes_next;
  logic                  header_found, header_found_next;
  logic [COUNT_BITS-1:0] header_end, header_end_next;
  logic                  finished, finished_next;
  logic [1:0]            finish_reason, finish_reason_next;

  logic                   take;
  logic                   byte_in;
  logic                   scan;
  logic                   clear;
  logic [COUNT_BITS-1:0]  body_bytes;
  logic [STATUS_BITS-1:0] status_next;
  logic [LENGTH_BITS-1:0] length_next;
  logic [CFG_BITS-1:0]    size_less_one;

  // handshakes
  assign cfg.ready = 1'b1;
  assign rx.ready  = !result.valid || result.ready;
  assign take      = rx.valid && rx.ready;
  assign clear     = take && (rx.kind == KIND_START);
  assign byte_in   = take && (rx.kind == KIND_DATA) && !finished && (byte_count < limit);
  assign scan      = byte_in && !header_found;

  // byte limit from buffer size, capped at the counter maximum
  assign size_less_one = cfg.buffer_size - 1'b1;
  always_comb begin
    if (cfg.buffer_size == '0) begin
      limit_next = '0;
    end else if (size_less_one[CFG_BITS-1:COUNT_BITS] != '0) begin
      limit_next = '1;
    end else begin
      limit_next = size_less_one[COUNT_BITS-1:0];
    end
  end

  hrhs_field_parse u_field_parse (
    .clk         (clk),
    .rst         (rst),
    .clear       (clear),
    .scan        (scan),
    .data_byte   (rx.data_byte),
    .status_next (status_next),
    .length_next (length_next)
  );

  assign body_bytes = byte_count_next - header_end_next;

  // per-item update of count, header end and completion
  always_comb begin
    byte_count_next    = byte_count;
    recent_bytes_next  = recent_bytes;
    header_found_next  = header_found;
    header_end_next    = header_end;
    finished_next      = finished;
    finish_reason_next = finish_reason;
    if (take) begin
      case (rx.kind)
        KIND_DATA: begin
          if (!finished) begin
            if (byte_count >= limit) begin
              finished_next      = 1'b1;
              finish_reason_next = STOP_FULL;
            end else begin
              byte_count_next   = byte_count + 1'b1;
              recent_bytes_next = {recent_bytes[15:0], rx.data_byte};
              if (!header_found && {recent_bytes, rx.data_byte} == HEADER_END) begin
                header_found_next = 1'b1;
                header_end_next   = byte_count + 1'b1;
              end
              if (header_found_next && length_next != '0 &&
                  {{(LENGTH_BITS-COUNT_BITS){1'b0}}, body_bytes} >= length_next) begin
                finished_next      = 1'b1;
                finish_reason_next = STOP_BODY;
              end else if (byte_count_next >= limit) begin
                finished_next      = 1'b1;
                finish_reason_next = STOP_FULL;
              end
            end
          end
        end
        KIND_CLOSE: begin
          if (!finished) begin
            finished_next      = 1'b1;
            finish_reason_next = STOP_CLOSED;
          end
        end
        KIND_START: begin
          byte_count_next    = '0;
          recent_bytes_next  = '0;
          header_found_next  = 1'b0;
          header_end_next    = '0;
          finished_next      = 1'b0;
          finish_reason_next = STOP_RUNNING;
        end
        default: ;
      endcase
    end
  end

  // scanner state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      limit         <= COUNT_BITS'(BUFFER_SIZE_RESET - 1'b1);
      byte_count    <= '0;
      recent_bytes  <= '0;
      header_found  <= 1'b0;
      header_end    <= '0;
      finished      <= 1'b0;
      finish_reason <= STOP_RUNNING;
    end else begin
      if (cfg.valid) limit <= limit_next;
      byte_count    <= byte_count_next;
      recent_bytes  <= recent_bytes_next;
      header_found  <= header_found_next;
      header_end    <= header_end_next;
      finished      <= finished_next;
      finish_reason <= finish_reason_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      result.header_done    <= header_found_next;
      result.header_length  <= header_end_next;
      result.status_code    <= status_next;
      result.content_length <= length_next;
      result.total_bytes    <= byte_count_next;
      result.done_res       <= finished_next;
      result.stop_reason    <= finish_reason_next;
    end
  end

endmodule
`default_nettype wire

### sv/hrhs_field_parse.sv
// status code and content-length field parser for header bytes
`default_nettype none
module hrhs_field_parse import hrhs_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   clear,
  input  wire logic                   scan,
  input  wire logic [7:0]             data_byte,
  output logic [STATUS_BITS-1:0]      status_next,
  output logic [LENGTH_BITS-1:0]      length_next
);

  // status parse phases
  localparam logic [1:0] ST_WAIT_SPACE = 2'd0;
  localparam logic [1:0] ST_DIGITS     = 2'd1;
  localparam logic [1:0] ST_DONE       = 2'd2;

  // length parse phases
  localparam logic [1:0] LN_KEY    = 2'd0;
  localparam logic [1:0] LN_SPACES = 2'd1;
  localparam logic [1:0] LN_DIGITS = 2'd2;
  localparam logic [1:0] LN_DONE   = 2'd3;

  localparam logic [KEY_POS_BITS-1:0] KEY_MISS = '1;
  localparam logic [KEY_POS_BITS-1:0] KEY_LAST = KEY_POS_BITS'(KEY_LENGTH - 1);

  logic [1:0]              status_phase, status_phase_next;
  logic [STATUS_BITS-1:0]  status_value;
  logic [1:0]              length_phase, length_phase_next;
  logic [LENGTH_BITS-1:0]  length_value;
  logic [KEY_POS_BITS-1:0] key_pos, key_pos_next;

  logic [7:0]             lower_byte;
  logic [3:0]             digit;
  logic [STATUS_BITS+3:0] status_sum;

  assign lower_byte = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
  assign digit      = 4'(data_byte - CHAR_ZERO);
  assign status_sum = ({4'd0, status_value} << 3) + ({4'd0, status_value} << 1)
                    + (STATUS_BITS+4)'(digit);

  // status code after the first space, saturating
  always_comb begin
    status_phase_next = status_phase;
    status_next       = status_value;
    if (clear) begin
      status_phase_next = ST_WAIT_SPACE;
      status_next       = '0;
    end else if (scan) begin
      unique case (status_phase)
        ST_WAIT_SPACE: begin
          if (data_byte == CHAR_SPACE) status_phase_next = ST_DIGITS;
        end
        ST_DIGITS: begin
          if (is_digit(data_byte)) begin
            status_next = (status_sum[STATUS_BITS+3:STATUS_BITS] != '0) ?
                          '1 : status_sum[STATUS_BITS-1:0];
          end else begin
            status_phase_next = ST_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // content-length key match and decimal value
  always_comb begin
    length_phase_next = length_phase;
    length_next       = length_value;
    key_pos_next      = key_pos;
    if (clear) begin
      length_phase_next = LN_KEY;
      length_next       = '0;
      key_pos_next      = '0;
    end else if (scan) begin
      unique case (length_phase)
        LN_KEY: begin
          if (key_pos <= KEY_LAST && lower_byte == key_char(key_pos)) begin
            key_pos_next = key_pos + 1'b1;
            if (key_pos == KEY_LAST) length_phase_next = LN_SPACES;
          end else if (data_byte == CHAR_LF) begin
            key_pos_next = '0;
          end else begin
            key_pos_next = KEY_MISS;
          end
        end
        LN_SPACES: begin
          if (data_byte != CHAR_SPACE) begin
            if (is_digit(data_byte)) begin
              length_next       = LENGTH_BITS'(digit);
              length_phase_next = LN_DIGITS;
            end else begin
              length_phase_next = LN_DONE;
            end
          end
        end
        LN_DIGITS: begin
          if (is_digit(data_byte)) begin
            length_next = (length_value << 3) + (length_value << 1) + LENGTH_BITS'(digit);
          end else begin
            length_phase_next = LN_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      status_phase <= ST_WAIT_SPACE;
      status_value <= '0;
      length_phase <= LN_KEY;
      length_value <= '0;
      key_pos      <= '0;
    end else begin
      status_phase <= status_phase_next;
      status_value <= status_next;
      length_phase <= length_phase_next;
      length_value <= length_next;
      key_pos      <= key_pos_next;
    end
  end

endmodule
`default_nettype wire

### dv/tb.sv
// testbench of the http response header scanner: directed and random items against a predictor
`timescale 1ns / 1ps
module tb;
  import hrhs_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [KEY_POS_BITS-1:0] KEY_MISS = 5'd31;
  localparam logic [CFG_BITS-1:0] COUNT_MAX = CFG_BITS'((1 << COUNT_BITS) - 1);
  localparam logic [8*KEY_LENGTH-1:0] LENGTH_KEY = "content-length:";
  localparam int STUCK_LIMIT = 2000;
  localparam int GAP_PERCENT = 37;

  typedef enum logic [1:0] {STATUS_WAIT_SPACE, STATUS_DIGITS, STATUS_DONE} status_phase_e;
  typedef enum logic [1:0] {LENGTH_KEY_MATCH, LENGTH_SPACES, LENGTH_DIGITS, LENGTH_DONE}
    length_phase_e;

  typedef struct {
    logic [COUNT_BITS-1:0]   count;
    logic [23:0]             recent;
    logic                    hdr_seen;
    logic [COUNT_BITS-1:0]   hdr_end;
    status_phase_e           status_phase;
    logic [STATUS_BITS-1:0]  status;
    logic [KEY_POS_BITS-1:0] key_pos;
    length_phase_e           length_phase;
    logic [LENGTH_BITS-1:0]  length;
    logic                    finished;
    logic [1:0]              reason;
  } scan_state_t;

  typedef struct {
    logic                   header_done;
    logic [COUNT_BITS-1:0]  header_length;
    logic [STATUS_BITS-1:0] status_code;
    logic [LENGTH_BITS-1:0] content_length;
    logic [COUNT_BITS-1:0]  total_bytes;
    logic                   done_res;
    logic [1:0]             stop_reason;
  } scan_result_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] value;
  } rx_item_t;

  logic clk;
  logic rst;

  hrhs_in_if  rx_if();
  hrhs_out_if res_if();
  hrhs_cfg_if cfg_if();

  http_response_header_scanner dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .result(res_if),
    .cfg(cfg_if)
  );

  // predictor state and bookkeeping
  scan_state_t         scan;
  logic [CFG_BITS-1:0] size_reg;
  scan_result_t        expected[$];
  rx_item_t            pending[$];
  int                  outstanding;
  int                  mismatches;
  int                  sent_items;
  int                  quiet_cycles;
  bit                  calm;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_scan();
    scan.count        = '0;
    scan.recent       = '0;
    scan.hdr_seen     = 1'b0;
    scan.hdr_end      = '0;
    scan.status_phase = STATUS_WAIT_SPACE;
    scan.status       = '0;
    scan.key_pos      = '0;
    scan.length_phase = LENGTH_KEY_MATCH;
    scan.length       = '0;
    scan.finished     = 1'b0;
    scan.reason       = STOP_RUNNING;
  endfunction

  // update the scanner state with one item and return what it reports
  function automatic scan_result_t scan_item(input logic [1:0] kind, input logic [7:0] b);
    scan_result_t        r;
    logic [CFG_BITS-1:0] limit;
    logic [31:0]         window;
    logic [31:0]         status_next;
    logic [7:0]          lower;
    logic                is_num;
    window = {scan.recent, b};
    is_num = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    lower  = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    limit  = (size_reg != '0) ? size_reg - 1'b1 : '0;
    if (limit > COUNT_MAX) limit = COUNT_MAX;
    case (kind)
      KIND_DATA: begin
        if (!scan.finished) begin
          if (CFG_BITS'(scan.count) >= limit) begin
            // byte refused at the limit
            scan.finished = 1'b1;
            scan.reason   = STOP_FULL;
          end else begin
            scan.count = scan.count + 1'b1;
            if (!scan.hdr_seen) begin
              // status code after the first space
              case (scan.status_phase)
                STATUS_WAIT_SPACE: begin
                  if (b == CHAR_SPACE) scan.status_phase = STATUS_DIGITS;
                end
                STATUS_DIGITS: begin
                  if (is_num) begin
                    status_next = 32'(scan.status) * 32'd10 + 32'(b - CHAR_ZERO);
                    scan.status = (status_next > 32'd65535) ? 16'hFFFF : status_next[15:0];
                  end else begin
                    scan.status_phase = STATUS_DONE;
                  end
                end
                default: ;
              endcase
              // content-length key and value
              case (scan.length_phase)
                LENGTH_KEY_MATCH: begin
                  if (scan.key_pos < KEY_LENGTH &&
                      lower == LENGTH_KEY[8*(KEY_LENGTH-1-scan.key_pos) +: 8]) begin
                    scan.key_pos = scan.key_pos + 1'b1;
                    if (scan.key_pos == KEY_LENGTH) scan.length_phase = LENGTH_SPACES;
                  end else if (b == CHAR_LF) begin
                    scan.key_pos = '0;
                  end else begin
                    scan.key_pos = KEY_MISS;
                  end
                end
                LENGTH_SPACES: begin
                  if (b != CHAR_SPACE) begin
                    if (is_num) begin
                      scan.length       = 32'(b - CHAR_ZERO);
                      scan.length_phase = LENGTH_DIGITS;
                    end else begin
                      scan.length_phase = LENGTH_DONE;
                    end
                  end
                end
                LENGTH_DIGITS: begin
                  if (is_num) scan.length = scan.length * 32'd10 + 32'(b - CHAR_ZERO);
                  else scan.length_phase = LENGTH_DONE;
                end
                default: ;
              endcase
              if (window == 32'h0D0A0D0A) begin
                scan.hdr_seen = 1'b1;
                scan.hdr_end  = scan.count;
              end
            end
            scan.recent = window[23:0];
            // body completion wins over buffer full
            if (scan.hdr_seen && scan.length != '0 &&
                LENGTH_BITS'(scan.count - scan.hdr_end) >= scan.length) begin
              scan.finished = 1'b1;
              scan.reason   = STOP_BODY;
            end else if (CFG_BITS'(scan.count) >= limit) begin
              scan.finished = 1'b1;
              scan.reason   = STOP_FULL;
            end
          end
        end
      end
      KIND_CLOSE: begin
        if (!scan.finished) begin
          scan.finished = 1'b1;
          scan.reason   = STOP_CLOSED;
        end
      end
      KIND_START: clear_scan();
      default: ;
    endcase
    r.header_done    = scan.hdr_seen;
    r.header_length  = scan.hdr_end;
    r.status_code    = scan.status;
    r.content_length = scan.length;
    r.total_bytes    = scan.count;
    r.done_res       = scan.finished;
    r.stop_reason    = scan.reason;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: register writes, accepted items and result checks
  always @(posedge clk) begin : monitor
    scan_result_t want;
    if (rst) begin
      clear_scan();
      size_reg = BUFFER_SIZE_RESET;
      expected.delete();
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (res_if.valid && res_if.ready) begin
        quiet_cycles = 0;
        if (expected.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatches++;
        end else begin
          want = expected.pop_front();
          check_field("header_done", 32'(want.header_done), 32'(res_if.header_done));
          check_field("header_length", 32'(want.header_length), 32'(res_if.header_length));
          check_field("status_code", 32'(want.status_code), 32'(res_if.status_code));
          check_field("content_length", want.content_length, res_if.content_length);
          check_field("total_bytes", 32'(want.total_bytes), 32'(res_if.total_bytes));
          check_field("done_res", 32'(want.done_res), 32'(res_if.done_res));
          check_field("stop_reason", 32'(want.stop_reason), 32'(res_if.stop_reason));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        quiet_cycles = 0;
        size_reg = cfg_if.buffer_size;
      end
      if (rx_if.valid && rx_if.ready) begin
        quiet_cycles = 0;
        expected.push_back(scan_item(rx_if.kind, rx_if.data_byte));
      end
    end
    outstanding = expected.size();
  end

  // result side stalls
  always @(negedge clk) begin
    res_if.ready <= calm || ($urandom_range(0, 99) >= GAP_PERCENT);
  end

  // watchdog on cycles with nothing accepted
  initial begin
    while (quiet_cycles < STUCK_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // send one item; called with the clock low
  task automatic send_item(input logic [1:0] kind, input logic [7:0] value);
    sent_items++;
    while (!calm && $urandom_range(0, 99) < GAP_PERCENT) begin
      rx_if.valid = 1'b0;
      @(negedge clk);
    end
    rx_if.valid     = 1'b1;
    rx_if.kind      = kind;
    rx_if.data_byte = value;
    do @(posedge clk); while (!rx_if.ready);
    @(negedge clk);
    rx_if.valid = 1'b0;
  endtask

  // register write once every result is in
  task automatic write_buffer_size(input logic [CFG_BITS-1:0] size);
    wait (outstanding == 0);
    @(negedge clk);
    cfg_if.valid       = 1'b1;
    cfg_if.buffer_size = size;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // response building
  function automatic void queue_item(input logic [1:0] kind, input logic [7:0] value);
    rx_item_t it;
    it.kind  = kind;
    it.value = value;
    pending.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_item(KIND_DATA, s[i]);
  endfunction

  function automatic void push_crlf();
    queue_item(KIND_DATA, CHAR_CR);
    queue_item(KIND_DATA, CHAR_LF);
  endfunction

  function automatic void push_digit();
    queue_item(KIND_DATA, CHAR_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void push_word(input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      c = "a" + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1) == 1) c = c - 8'd32;
      queue_item(KIND_DATA, c);
    end
  endfunction

  function automatic void push_filler_line();
    if ($urandom_range(0, 2) == 0) begin
      push_text("Content-Type: text");
    end else begin
      push_word($urandom_range(1, 6));
      push_text(": ");
      push_word($urandom_range(0, 4));
    end
    push_crlf();
  endfunction

  // content-length line in random case; returns the short length it writes, else zero
  function automatic int unsigned push_length_line();
    logic [7:0]  c;
    int unsigned pick;
    int unsigned v;
    v = 0;
    for (int i = 0; i < KEY_LENGTH; i++) begin
      c = LENGTH_KEY[8*(KEY_LENGTH-1-i) +: 8];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      if ($urandom_range(0, 39) == 0) c = "x";
      queue_item(KIND_DATA, c);
    end
    repeat ($urandom_range(0, 2)) queue_item(KIND_DATA, CHAR_SPACE);
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      v = $urandom_range(0, 40);
      push_text($sformatf("%0d", v));
    end else if (pick < 16) begin
      // long value that may wrap
      repeat ($urandom_range(9, 12)) push_digit();
    end else begin
      push_word(1);
      push_digit();
    end
    push_crlf();
    return v;
  endfunction

  function automatic void build_response();
    int unsigned pick;
    int unsigned body;
    body = $urandom_range(0, 12);
    if ($urandom_range(0, 99) < 85) queue_item(KIND_START, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) begin
      // noise leaning on line ends, spaces and digits
      repeat ($urandom_range(4, 40)) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       queue_item(KIND_CLOSE, 8'($urandom_range(0, 255)));
          1:       queue_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
          2:       queue_item(KIND_START, 8'($urandom_range(0, 255)));
          3, 4, 5: queue_item(KIND_DATA, CHAR_CR);
          6, 7:    queue_item(KIND_DATA, CHAR_LF);
          8:       queue_item(KIND_DATA, CHAR_SPACE);
          9:       push_digit();
          default: queue_item(KIND_DATA, 8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      // status line
      push_word($urandom_range(1, 4));
      if ($urandom_range(0, 19) != 0) queue_item(KIND_DATA, CHAR_SPACE);
      if ($urandom_range(0, 9) == 0) push_word(1);
      repeat ($urandom_range(0, 6)) push_digit();
      push_text(" OK");
      push_crlf();
      // header lines
      repeat ($urandom_range(0, 1)) push_filler_line();
      if ($urandom_range(0, 99) < 80) begin
        pick = push_length_line();
        if (pick != 0) body = pick + $urandom_range(0, 2);
      end
      if ($urandom_range(0, 4) == 0) pick = push_length_line();
      repeat ($urandom_range(0, 1)) push_filler_line();
      if ($urandom_range(0, 9) != 0) push_crlf();
      // body
      repeat (body) queue_item(KIND_DATA, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 30) queue_item(KIND_CLOSE, 8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_pending(input bit sprinkle);
    rx_item_t it;
    while (pending.size() > 0) begin
      it = pending.pop_front();
      if (sprinkle && $urandom_range(0, 49) == 0)
        send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
      send_item(it.kind, it.value);
    end
  endtask

  // events, field extremes and close after finish
  task automatic test_events();
    send_item(KIND_UNUSED, 8'hFF);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_CLOSE, 8'hA5);
    send_item(KIND_CLOSE, 8'h00);
    send_item(KIND_DATA, 8'h41);
    send_item(KIND_START, 8'h00);
  endtask

  // buffer sizes of zero, one and two
  task automatic test_tiny_buffer();
    write_buffer_size('0);
    send_item(KIND_DATA, "a");
    send_item(KIND_START, 8'h00);
    write_buffer_size(CFG_BITS'(1));
    send_item(KIND_DATA, "a");
    send_item(KIND_START, 8'h00);
    write_buffer_size(CFG_BITS'(2));
    send_item(KIND_DATA, "a");
    send_item(KIND_DATA, "b");
    send_item(KIND_START, 8'h00);
  endtask

  // saturating status, mixed-case key, body complete, then close and bytes ignored
  task automatic test_header_parse();
    write_buffer_size(BUFFER_SIZE_RESET);
    push_text(" 70000");
    push_crlf();
    push_text("cOnTeNt-LeNgTh: 2");
    push_crlf();
    push_crlf();
    push_text("ab");
    queue_item(KIND_CLOSE, 8'h00);
    queue_item(KIND_DATA, "c");
    send_pending(1'b0);
  endtask

  // random responses over several buffer sizes, one phase without idling
  task automatic test_random_responses();
    logic [CFG_BITS-1:0] sizes[8];
    int goal;
    sizes = '{BUFFER_SIZE_RESET, CFG_BITS'(2), CFG_BITS'(1048576), {CFG_BITS{1'b1}},
              CFG_BITS'(0), CFG_BITS'($urandom_range(40, 400)),
              CFG_BITS'($urandom_range(40, 400)), CFG_BITS'(3)};
    for (int p = 0; p < 8; p++) begin
      write_buffer_size(sizes[p]);
      calm = (p == 5);
      goal = sent_items + 250;
      while (sent_items < goal) begin
        build_response();
        send_pending(1'b1);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst                = 1'b1;
    calm               = 1'b0;
    mismatches         = 0;
    sent_items         = 0;
    quiet_cycles       = 0;
    outstanding        = 0;
    rx_if.valid        = 1'b0;
    rx_if.kind         = KIND_DATA;
    rx_if.data_byte    = 8'h00;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.buffer_size = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_events();
    test_tiny_buffer();
    test_header_parse();
    test_random_responses();

    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### http_response_header_scanner.f
sv/hrhs_pkg.sv
sv/hrhs_ifs.sv
sv/hrhs_field_parse.sv
sv/http_response_header_scanner.sv
dv/tb.sv
